>>> hdl/datetime_difference_core_assert.svh
// Assertion macros shared by the datetime difference block.
`ifndef DATETIME_DIFFERENCE_CORE_ASSERT_SVH
`define DATETIME_DIFFERENCE_CORE_ASSERT_SVH
// Checks that a condition implies another at the same edge.
`define DTD_ASSERT_IMP(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("assertion failed");
// Checks that a condition implies another at the next edge.
`define DTD_ASSERT_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> hdl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// Datetime difference package
// Shared constants and calendar helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dtd_pkg;
  localparam int unsigned YEAR_MAX_DEF = 9999;
  localparam int unsigned DAYS_W = 22;
  // Day count of 3.10.2022 since 1.1.0001.
  localparam logic [DAYS_W-1:0] REF_DAYS = 22'(2021*365 + 2021/4 + 273 + 2);

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [16:0]       tod;
  } stamp_t;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd1: s = 9'd0;
      4'd2: s = 9'd31;
      4'd3: s = 9'd59;
      4'd4: s = 9'd90;
      4'd5: s = 9'd120;
      4'd6: s = 9'd151;
      4'd7: s = 9'd181;
      4'd8: s = 9'd212;
      4'd9: s = 9'd243;
      4'd10: s = 9'd273;
      4'd11: s = 9'd304;
      4'd12: s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m > 4'd2) s = s + 9'd1;
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m) inside
      4'd2: l = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction
endpackage

>>> hdl/dtd_stamp.sv
// ----------------------------------------------------------------------------
// Datetime difference stamp conversion
// Checks one stamp and turns it into a day count and a second of day.
// Two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dtd_stamp import dtd_pkg::*; #(
  parameter int unsigned YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [6:0]  day,
  input  logic [6:0]  month,
  input  logic [13:0] year,
  input  logic [6:0]  hour,
  input  logic [6:0]  minute,
  input  logic [6:0]  second,
  output logic        ok,
  output stamp_t      stamp
);
  logic              leap;
  logic              ok_nxt, ok_r, ok2_r;
  logic [DAYS_W-1:0] ybase_r;
  logic [8:0]        yday_r;
  logic [16:0]       tod_r, tod2_r;
  logic [DAYS_W-1:0] days_r;
  logic [13:0]       y1;

  assign leap = (year[1:0] == 2'b00);
  assign y1   = year - 14'd1;

  always_comb begin
    ok_nxt = (year != 14'd0) && (32'(year) <= YEAR_MAX) && (month >= 7'd1)
           && (month <= 7'd12) && (day >= 7'd1)
           && (day <= 7'(month_len(month[3:0], leap)))
           && (hour < 7'd24) && (minute < 7'd60) && (second < 7'd60);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r    <= ok_nxt;
      ybase_r <= DAYS_W'(y1) * DAYS_W'(365) + DAYS_W'(y1[13:2]);
      yday_r  <= month_start(month[3:0], leap) + 9'(day[4:0]) - 9'd1;
      tod_r   <= 17'(hour[4:0]) * 17'd3600 + 17'(minute[5:0]) * 17'd60
               + 17'(second[5:0]);
      ok2_r   <= ok_r;
      days_r  <= ybase_r + DAYS_W'(yday_r);
      tod2_r  <= tod_r;
    end
  end

  assign ok          = ok2_r;
  assign stamp.days  = days_r;
  assign stamp.tod   = tod2_r;
endmodule

>>> hdl/datetime_difference_core.sv
// ----------------------------------------------------------------------------
// Datetime difference core
// Difference of two calendar stamps and weekday of the first.
// ----------------------------------------------------------------------------
// One stamp pair enters every cycle in which the output word is not stalled:
// two stages convert the stamps, one compares them and takes the day and
// time-of-day differences, one settles the borrow between the two and reduces
// the weekday distance, one splits off the hours and one splits the rest into
// minutes and seconds. The whole pipeline advances only when the output word
// is not stalled, so a stall holds every stage and nothing is lost.
`timescale 1ns / 1ps
`include "datetime_difference_core_assert.svh"
module datetime_difference_core import dtd_pkg::*; #(
  parameter int unsigned YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_first_day,
  input  logic [6:0]  in_first_month,
  input  logic [13:0] in_first_year,
  input  logic [6:0]  in_first_hour,
  input  logic [6:0]  in_first_minute,
  input  logic [6:0]  in_first_second,
  input  logic [6:0]  in_other_day,
  input  logic [6:0]  in_other_month,
  input  logic [13:0] in_other_year,
  input  logic [6:0]  in_other_hour,
  input  logic [6:0]  in_other_minute,
  input  logic [6:0]  in_other_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_stamps_valid,
  output logic        out_first_not_earlier,
  output logic [5:0]  out_gap_seconds,
  output logic [5:0]  out_gap_minutes,
  output logic [4:0]  out_gap_hours,
  output logic [21:0] out_gap_days,
  output logic [2:0]  out_weekday
);
  localparam logic [16:0] HOUR_RECIP = 17'd74566;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;

  logic        en;
  logic [5:0]  vld_r;
  logic        f_ok, o_ok;
  stamp_t      f_st, o_st;

  logic              fne;
  logic [DAYS_W-1:0] ddf, ddo;
  logic [17:0]       dtf, dto;
  logic              ok3_r, fne3_r;
  logic [DAYS_W-1:0] dd3_r;
  logic [17:0]       dt3_r;
  logic [DAYS_W-1:0] wdd3_r;
  logic              wdneg3_r;

  logic              ok4_r, fne4_r;
  logic [DAYS_W-1:0] days4_r;
  logic [16:0]       tod4_r;
  logic [2:0]        wd4_r;
  logic [DAYS_W-1:0] dq;
  logic [16:0]       dr;
  logic [5:0]        oct_sum;
  logic [3:0]        oct_fold;
  logic [2:0]        oct_mod;
  logic [2:0]        wdm;

  logic              ok5_r, fne5_r;
  logic [DAYS_W-1:0] days5_r;
  logic [4:0]        hr5_r;
  logic [11:0]       rem5_r;
  logic [2:0]        wd5_r;
  logic [32:0]       hprod;
  logic [4:0]        hq;
  logic [11:0]       hrem;

  logic              ok6_r, fne6_r;
  logic [DAYS_W-1:0] days6_r;
  logic [4:0]        hr6_r;
  logic [5:0]        mn6_r, sc6_r;
  logic [2:0]        wd6_r;
  logic [23:0]       mprod;
  logic [5:0]        mq;
  logic [5:0]        sq;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  dtd_stamp #(.YEAR_MAX(YEAR_MAX)) u_first (
    .clk(clk), .en(en), .day(in_first_day), .month(in_first_month),
    .year(in_first_year), .hour(in_first_hour), .minute(in_first_minute),
    .second(in_first_second), .ok(f_ok), .stamp(f_st)
  );
  dtd_stamp #(.YEAR_MAX(YEAR_MAX)) u_other (
    .clk(clk), .en(en), .day(in_other_day), .month(in_other_month),
    .year(in_other_year), .hour(in_other_hour), .minute(in_other_minute),
    .second(in_other_second), .ok(o_ok), .stamp(o_st)
  );

  assign fne = (f_st.days > o_st.days)
             || ((f_st.days == o_st.days) && (f_st.tod >= o_st.tod));
  assign ddf = f_st.days - o_st.days;
  assign ddo = o_st.days - f_st.days;
  assign dtf = {1'b0, f_st.tod} - {1'b0, o_st.tod};
  assign dto = {1'b0, o_st.tod} - {1'b0, f_st.tod};

  // Stage 3: day and time-of-day differences and distance to the weekday reference.
  always_ff @(posedge clk) begin
    if (en) begin
      ok3_r    <= f_ok && o_ok;
      fne3_r   <= fne;
      dd3_r    <= fne ? ddf : ddo;
      dt3_r    <= fne ? dtf : dto;
      wdneg3_r <= f_st.days < REF_DAYS;
      wdd3_r   <= (f_st.days >= REF_DAYS) ? f_st.days - REF_DAYS
                                          : REF_DAYS - f_st.days;
    end
  end

  // Stage 4: borrow a day when the time of day went negative, and mod 7 by
  // summing octal digits.
  always_comb begin
    dq  = dt3_r[17] ? dd3_r - DAYS_W'(1) : dd3_r;
    dr  = dt3_r[17] ? dt3_r[16:0] + 17'd86400 : dt3_r[16:0];
    oct_sum = 6'(wdd3_r[2:0]) + 6'(wdd3_r[5:3]) + 6'(wdd3_r[8:6])
            + 6'(wdd3_r[11:9]) + 6'(wdd3_r[14:12]) + 6'(wdd3_r[17:15])
            + 6'(wdd3_r[20:18]) + {5'd0, wdd3_r[21]};
    oct_fold = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
    oct_mod  = {2'b00, oct_fold[3]} + oct_fold[2:0];
    wdm = (oct_mod == 3'd7) ? 3'd0 : oct_mod;
    if (wdneg3_r && wdm != 3'd0) wdm = 3'd7 - wdm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4_r   <= ok3_r;
      fne4_r  <= fne3_r;
      days4_r <= dq;
      tod4_r  <= dr;
      wd4_r   <= wdm;
    end
  end

  // Stage 5: hours by a reciprocal multiply.
  always_comb begin
    hprod = 33'(tod4_r) * 33'(HOUR_RECIP);
    hq    = hprod[32:28];
    hrem  = 12'(tod4_r - 17'(hq) * 17'd3600);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5_r   <= ok4_r;
      fne5_r  <= fne4_r;
      days5_r <= days4_r;
      hr5_r   <= hq;
      rem5_r  <= hrem;
      wd5_r   <= wd4_r;
    end
  end

  // Stage 6: minutes and seconds by a reciprocal multiply.
  always_comb begin
    mprod = 24'(rem5_r) * 24'(MIN_RECIP);
    mq    = mprod[23:18];
    sq    = 6'(rem5_r - 12'(mq) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok6_r   <= ok5_r;
      fne6_r  <= fne5_r;
      days6_r <= days5_r;
      hr6_r   <= hr5_r;
      mn6_r   <= mq;
      sc6_r   <= sq;
      wd6_r   <= wd5_r;
    end
  end

  assign out_valid             = vld_r[5];
  assign out_stamps_valid      = ok6_r;
  assign out_first_not_earlier = ok6_r & fne6_r;
  assign out_gap_seconds       = ok6_r ? sc6_r : '0;
  assign out_gap_minutes       = ok6_r ? mn6_r : '0;
  assign out_gap_hours         = ok6_r ? hr6_r : '0;
  assign out_gap_days          = ok6_r ? days6_r : '0;
  assign out_weekday           = ok6_r ? wd6_r : '0;

  `DTD_ASSERT_IMP(a_stall_only_when_blocked, clk, rst_n, in_stall, out_valid && out_stall)
  `DTD_ASSERT_NEXT(a_valid_advances, clk, rst_n, en && vld_r[4], out_valid)
  `DTD_ASSERT_IMP(a_weekday_range, clk, rst_n, out_valid, out_weekday != 3'd7)
  `DTD_ASSERT_IMP(a_hours_range, clk, rst_n, out_valid, out_gap_hours < 5'd24)
endmodule
